// ===== rtl/core/lrt_pkg.sv =====
// ============================================================================
// lrt_pkg: shared types and functions of the lazy range tree engine
// node layout, command classes, combine functions and sequencer states
// ============================================================================
package lrt_pkg;

    localparam int SIZE       = 1024;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = 10;
    localparam int LOG_LEAVES = $clog2(SIZE);
    localparam int LEAVES     = 1 << LOG_LEAVES;
    localparam int NODES      = 2 * LEAVES;
    localparam int NODE_W     = LOG_LEAVES + 1;
    localparam int POS_W      = LOG_LEAVES + 2;
    localparam int LEV_W      = $clog2(LOG_LEAVES + 2);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [1:0] KIND_QUERY  = 2'd0;
    localparam logic [1:0] KIND_COMB   = 2'd1;
    localparam logic [1:0] KIND_ASSIGN = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef logic [VALUE_BITS-1:0] val_t;

    typedef enum logic [1:0] {
        OP_SUM,
        OP_MIN,
        OP_MAX,
        OP_XOR
    } op_t;

    typedef enum logic [1:0] {
        CLS_QUERY,
        CLS_EMPTYQ,
        CLS_COMB,
        CLS_ASSIGN
    } cls_t;

    typedef struct packed {
        cls_t              cls;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
        val_t              val;
    } cmd_t;

    // tree node: aggregate includes own tag, tag is pending for the children
    typedef struct packed {
        logic mk;
        val_t lz;
        val_t d;
    } node_t;

    typedef struct packed {
        logic clearing;
    } stat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUSH_SEL,
        ST_PUSH_P1,
        ST_PUSH_P2,
        ST_PUSH_P3,
        ST_LOOP_SEL,
        ST_LOOP_W,
        ST_UPD_SEL,
        ST_UPD_A,
        ST_UPD_B,
        ST_OUT
    } state_t;

    function automatic val_t ident(input op_t op);
        return (op == OP_MIN) ? '1 : '0;
    endfunction

    function automatic val_t comb(input op_t op, input val_t x, input val_t y);
        val_t r;
        case (op)
            OP_SUM:  r = x + y;
            OP_MIN:  r = (x < y) ? x : y;
            OP_MAX:  r = (x > y) ? x : y;
            default: r = x ^ y;
        endcase
        return r;
    endfunction

    // combine of 2**lev copies of v
    function automatic val_t scale(input op_t op, input val_t v, input logic [LEV_W-1:0] lev);
        val_t r;
        case (op)
            OP_SUM:  r = v << lev;
            OP_XOR:  r = (lev == '0) ? v : '0;
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic node_t apply(input op_t op, input node_t e, input logic amk,
                                    input val_t av, input logic [LEV_W-1:0] lev);
        node_t r;
        val_t  sc;
        sc   = scale(op, av, lev);
        r.d  = amk ? sc : comb(op, e.d, sc);
        r.lz = amk ? av : comb(op, e.lz, av);
        r.mk = amk | e.mk;
        return r;
    endfunction

endpackage

// ===== rtl/core/lrt_front.sv =====
// ============================================================================
// lrt_front: request intake
// clamps and classifies each beat, drops requests that change nothing
// ============================================================================
module lrt_front (
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              kind,
    input  logic [lrt_pkg::IDX_W-1:0] range_low,
    input  logic [lrt_pkg::IDX_W-1:0] range_high,
    input  lrt_pkg::val_t           value,
    input  lrt_pkg::stat_t          stat,
    output logic                    push_valid,
    input  logic                    push_ready,
    output lrt_pkg::cmd_t           push_data
);

    logic [lrt_pkg::IDX_W-1:0] hi_clamp;
    logic                      empty;
    logic                      keep;
    lrt_pkg::cls_t             cls;

    always_comb
    begin
        hi_clamp = (range_high > lrt_pkg::IDX_W'(lrt_pkg::SIZE - 1)) ?
                   lrt_pkg::IDX_W'(lrt_pkg::SIZE - 1) : range_high;
        empty    = range_low > hi_clamp;
        keep     = 1'b0;
        cls      = lrt_pkg::CLS_QUERY;
        unique case (kind)
            lrt_pkg::KIND_QUERY:
            begin
                keep = 1'b1;
                cls  = empty ? lrt_pkg::CLS_EMPTYQ : lrt_pkg::CLS_QUERY;
            end
            lrt_pkg::KIND_COMB:
            begin
                keep = !empty;
                cls  = lrt_pkg::CLS_COMB;
            end
            lrt_pkg::KIND_ASSIGN:
            begin
                keep = !empty;
                cls  = lrt_pkg::CLS_ASSIGN;
            end
            default:
            begin
                keep = 1'b0;
                cls  = lrt_pkg::CLS_QUERY;
            end
        endcase
    end

    // leaf positions, high end exclusive
    assign push_data.cls = cls;
    assign push_data.lo  = lrt_pkg::POS_W'(range_low) + lrt_pkg::POS_W'(lrt_pkg::LEAVES);
    assign push_data.hi  = lrt_pkg::POS_W'(hi_clamp) + lrt_pkg::POS_W'(lrt_pkg::LEAVES)
                           + lrt_pkg::POS_W'(1);
    assign push_data.val = value;

    assign in_ready   = push_ready & !stat.clearing;
    assign push_valid = in_valid & keep & !stat.clearing;

endmodule

// ===== rtl/core/lrt_queue.sv =====
// ============================================================================
// lrt_queue: command queue
// short fifo between intake and tree sequencer
// ============================================================================
module lrt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  lrt_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output lrt_pkg::cmd_t pop_data
);

    lrt_pkg::cmd_t                ent_reg [lrt_pkg::QDEPTH];
    logic [lrt_pkg::QPTR_W-1:0]   wp_reg;
    logic [lrt_pkg::QPTR_W-1:0]   wp_next;
    logic [lrt_pkg::QPTR_W-1:0]   rp_reg;
    logic [lrt_pkg::QPTR_W-1:0]   rp_next;
    logic [lrt_pkg::QPTR_W:0]     cnt_reg;
    logic [lrt_pkg::QPTR_W:0]     cnt_next;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = cnt_reg != (lrt_pkg::QPTR_W + 1)'(lrt_pkg::QDEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = ent_reg[rp_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb
    begin
        wp_next  = do_push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (lrt_pkg::QPTR_W + 1)'(do_push)
                   - (lrt_pkg::QPTR_W + 1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wp_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/lrt_back.sv =====
// ============================================================================
// lrt_back: tree sequencer
// node memory, push-down, boundary walk, ancestor rebuild, result register
// ============================================================================
module lrt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    combine_op,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  lrt_pkg::cmd_t pop_data,
    output lrt_pkg::stat_t stat,
    output logic          out_valid,
    input  logic          out_ready,
    output lrt_pkg::val_t result_value
);

    localparam int NW = lrt_pkg::NODE_W;
    localparam int PW = lrt_pkg::POS_W;
    localparam int LW = lrt_pkg::LEV_W;

    lrt_pkg::node_t mem [lrt_pkg::NODES];
    lrt_pkg::node_t rdata_reg;
    logic [NW-1:0]  rd_addr;
    logic           we;
    logic [NW-1:0]  wa;
    lrt_pkg::node_t wd;

    lrt_pkg::state_t state_reg, state_next;
    logic [NW-1:0]   clr_reg, clr_next;
    lrt_pkg::op_t    op_reg, op_next;
    logic            out_valid_reg, out_valid_next;
    lrt_pkg::val_t   out_data_reg, out_data_next;
    lrt_pkg::cls_t   cls_reg, cls_next;
    logic [PW-1:0]   l_reg, l_next, r_reg, r_next;
    logic [PW-1:0]   l0_reg, l0_next, r0_reg, r0_next;
    lrt_pkg::val_t   val_reg, val_next;
    logic [LW-1:0]   lev_reg, lev_next;
    logic            side_reg, side_next;
    logic [NW-1:0]   node_reg, node_next;
    lrt_pkg::val_t   acc_reg, acc_next;
    logic            tmk_reg, tmk_next;
    lrt_pkg::val_t   tlz_reg, tlz_next;
    lrt_pkg::val_t   hold_reg, hold_next;

    logic [PW-1:0]   sel_lo, sel_hi, low_mask, path_pos, path_shift, hi_dec;
    logic [NW-1:0]   path_node, lo_node, hi_node, kid_lo, kid_hi;
    logic            path_cond, last_push, last_upd, is_query;
    logic [LW-1:0]   child_lev;
    lrt_pkg::val_t   id_val;

    assign cfg_ready    = 1'b1;
    assign stat.clearing = state_reg == lrt_pkg::ST_CLEAR;
    assign out_valid    = out_valid_reg;
    assign result_value = out_data_reg;

    // path node at the current level on the low or high boundary
    assign sel_lo     = (state_reg == lrt_pkg::ST_UPD_SEL) ? l0_reg : l_reg;
    assign sel_hi     = (state_reg == lrt_pkg::ST_UPD_SEL) ? r0_reg : r_reg;
    assign low_mask   = (PW'(1) << lev_reg) - PW'(1);
    assign path_pos   = side_reg ? (sel_hi - PW'(1)) : sel_lo;
    assign path_cond  = ((side_reg ? sel_hi : sel_lo) & low_mask) != '0;
    assign path_shift = path_pos >> lev_reg;
    assign path_node  = path_shift[NW-1:0];
    assign hi_dec     = r_reg - PW'(1);
    assign lo_node    = l_reg[NW-1:0];
    assign hi_node    = hi_dec[NW-1:0];
    assign kid_lo     = {node_reg[NW-2:0], 1'b0};
    assign kid_hi     = {node_reg[NW-2:0], 1'b1};
    assign child_lev  = lev_reg - LW'(1);
    assign last_push  = lev_reg == LW'(1);
    assign last_upd   = lev_reg == LW'(lrt_pkg::LOG_LEAVES);
    assign is_query   = cls_reg == lrt_pkg::CLS_QUERY;
    assign id_val     = lrt_pkg::ident(op_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lrt_pkg::ST_CLEAR:
                if (clr_reg == '1) state_next = lrt_pkg::ST_IDLE;
            lrt_pkg::ST_IDLE:
                if (pop_valid)
                    state_next = (pop_data.cls == lrt_pkg::CLS_EMPTYQ) ?
                                 lrt_pkg::ST_OUT : lrt_pkg::ST_PUSH_SEL;
            lrt_pkg::ST_PUSH_SEL:
                if (path_cond) state_next = lrt_pkg::ST_PUSH_P1;
                else if (side_reg && last_push) state_next = lrt_pkg::ST_LOOP_SEL;
            lrt_pkg::ST_PUSH_P1:
                state_next = lrt_pkg::ST_PUSH_P2;
            lrt_pkg::ST_PUSH_P2:
                state_next = lrt_pkg::ST_PUSH_P3;
            lrt_pkg::ST_PUSH_P3:
                state_next = (side_reg && last_push) ? lrt_pkg::ST_LOOP_SEL
                                                     : lrt_pkg::ST_PUSH_SEL;
            lrt_pkg::ST_LOOP_SEL:
                if (!side_reg)
                begin
                    if (l_reg >= r_reg)
                        state_next = is_query ? lrt_pkg::ST_OUT : lrt_pkg::ST_UPD_SEL;
                    else if (l_reg[0])
                        state_next = lrt_pkg::ST_LOOP_W;
                end
                else if (r_reg[0])
                    state_next = lrt_pkg::ST_LOOP_W;
            lrt_pkg::ST_LOOP_W:
                state_next = lrt_pkg::ST_LOOP_SEL;
            lrt_pkg::ST_UPD_SEL:
                if (path_cond) state_next = lrt_pkg::ST_UPD_A;
                else if (side_reg && last_upd) state_next = lrt_pkg::ST_IDLE;
            lrt_pkg::ST_UPD_A:
                state_next = lrt_pkg::ST_UPD_B;
            lrt_pkg::ST_UPD_B:
                state_next = (side_reg && last_upd) ? lrt_pkg::ST_IDLE
                                                    : lrt_pkg::ST_UPD_SEL;
            lrt_pkg::ST_OUT:
                if (!out_valid_reg || out_ready) state_next = lrt_pkg::ST_IDLE;
            default:
                state_next = lrt_pkg::ST_IDLE;
        endcase
        if (cfg_valid) state_next = lrt_pkg::ST_CLEAR;
    end

    always_comb
    begin
        clr_next       = clr_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_data_next  = out_data_reg;
        cls_next       = cls_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        l0_next        = l0_reg;
        r0_next        = r0_reg;
        val_next       = val_reg;
        lev_next       = lev_reg;
        side_next      = side_reg;
        node_next      = node_reg;
        acc_next       = acc_reg;
        tmk_next       = tmk_reg;
        tlz_next       = tlz_reg;
        hold_next      = hold_reg;
        pop_ready      = 1'b0;
        rd_addr        = path_node;
        we             = 1'b0;
        wa             = node_reg;
        wd             = '0;
        unique case (state_reg)
            lrt_pkg::ST_CLEAR:
            begin
                we       = 1'b1;
                wa       = clr_reg;
                wd       = '{mk: 1'b0, lz: id_val, d: '0};
                clr_next = clr_reg + 1'b1;
            end
            lrt_pkg::ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    cls_next  = pop_data.cls;
                    l_next    = pop_data.lo;
                    r_next    = pop_data.hi;
                    l0_next   = pop_data.lo;
                    r0_next   = pop_data.hi;
                    val_next  = pop_data.val;
                    lev_next  = LW'(lrt_pkg::LOG_LEAVES);
                    side_next = 1'b0;
                    acc_next  = id_val;
                end
            end
            lrt_pkg::ST_PUSH_SEL:
            begin
                node_next = path_node;
                if (!path_cond)
                begin
                    side_next = !side_reg;
                    if (side_reg) lev_next = lev_reg - LW'(1);
                end
            end
            lrt_pkg::ST_PUSH_P1:
            begin
                // clear the tag of the node, keep its aggregate
                we       = 1'b1;
                wa       = node_reg;
                wd       = '{mk: 1'b0, lz: id_val, d: rdata_reg.d};
                tmk_next = rdata_reg.mk;
                tlz_next = rdata_reg.lz;
                rd_addr  = kid_lo;
            end
            lrt_pkg::ST_PUSH_P2:
            begin
                we      = 1'b1;
                wa      = kid_lo;
                wd      = lrt_pkg::apply(op_reg, rdata_reg, tmk_reg, tlz_reg, child_lev);
                rd_addr = kid_hi;
            end
            lrt_pkg::ST_PUSH_P3:
            begin
                we        = 1'b1;
                wa        = kid_hi;
                wd        = lrt_pkg::apply(op_reg, rdata_reg, tmk_reg, tlz_reg, child_lev);
                side_next = !side_reg;
                if (side_reg) lev_next = lev_reg - LW'(1);
            end
            lrt_pkg::ST_LOOP_SEL:
            begin
                if (!side_reg)
                begin
                    if (l_reg >= r_reg)
                    begin
                        lev_next = LW'(1);
                    end
                    else if (l_reg[0])
                    begin
                        rd_addr   = lo_node;
                        node_next = lo_node;
                        l_next    = l_reg + PW'(1);
                    end
                    else
                    begin
                        side_next = 1'b1;
                    end
                end
                else if (r_reg[0])
                begin
                    rd_addr   = hi_node;
                    node_next = hi_node;
                    r_next    = hi_dec;
                end
                else
                begin
                    l_next    = l_reg >> 1;
                    r_next    = r_reg >> 1;
                    lev_next  = lev_reg + LW'(1);
                    side_next = 1'b0;
                end
            end
            lrt_pkg::ST_LOOP_W:
            begin
                if (is_query)
                begin
                    acc_next = lrt_pkg::comb(op_reg, acc_reg, rdata_reg.d);
                end
                else
                begin
                    we = 1'b1;
                    wa = node_reg;
                    wd = lrt_pkg::apply(op_reg, rdata_reg, cls_reg == lrt_pkg::CLS_ASSIGN,
                                        val_reg, lev_reg);
                end
                if (!side_reg)
                begin
                    side_next = 1'b1;
                end
                else
                begin
                    l_next    = l_reg >> 1;
                    r_next    = r_reg >> 1;
                    lev_next  = lev_reg + LW'(1);
                    side_next = 1'b0;
                end
            end
            lrt_pkg::ST_UPD_SEL:
            begin
                rd_addr   = {path_node[NW-2:0], 1'b0};
                node_next = path_node;
                if (!path_cond)
                begin
                    side_next = !side_reg;
                    if (side_reg) lev_next = lev_reg + LW'(1);
                end
            end
            lrt_pkg::ST_UPD_A:
            begin
                hold_next = rdata_reg.d;
                rd_addr   = kid_hi;
            end
            lrt_pkg::ST_UPD_B:
            begin
                we        = 1'b1;
                wa        = node_reg;
                wd        = '{mk: 1'b0, lz: id_val,
                              d: lrt_pkg::comb(op_reg, hold_reg, rdata_reg.d)};
                side_next = !side_reg;
                if (side_reg) lev_next = lev_reg + LW'(1);
            end
            lrt_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
        if (cfg_valid)
        begin
            op_next  = lrt_pkg::op_t'(combine_op);
            clr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrt_pkg::ST_CLEAR;
            clr_reg       <= '0;
            op_reg        <= lrt_pkg::OP_SUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        cls_reg      <= cls_next;
        l_reg        <= l_next;
        r_reg        <= r_next;
        l0_reg       <= l0_next;
        r0_reg       <= r0_next;
        val_reg      <= val_next;
        lev_reg      <= lev_next;
        side_reg     <= side_next;
        node_reg     <= node_next;
        acc_reg      <= acc_next;
        tmk_reg      <= tmk_next;
        tlz_reg      <= tlz_next;
        hold_reg     <= hold_next;
    end

    // node memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rdata_reg <= mem[rd_addr];
    end

`ifndef SYNTH
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrt_pkg::ST_CLEAR) |-> !pop_ready)
        else $error("command taken during clearing pass");
    a_out_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrt_pkg::ST_OUT) |->
        (cls_reg == lrt_pkg::CLS_QUERY || cls_reg == lrt_pkg::CLS_EMPTYQ))
        else $error("result stage reached by an update");
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> (state_reg == lrt_pkg::ST_CLEAR))
        else $error("config write did not start a clearing pass");
    a_lev_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrt_pkg::ST_LOOP_SEL) |-> (lev_reg <= LW'(lrt_pkg::LOG_LEAVES + 1)))
        else $error("walk level out of range");
`endif

endmodule

// ===== rtl/core/lazy_range_tree_engine.sv =====
// flow: an empty query goes from the queue straight to the result register; a query
//   that walks the tree first runs its push-downs and its boundary walk
// sequencer: one request at a time; a walk holds the sequencer through its push-downs,
//   boundary nodes and, for an update, the ancestor rebuilds
// reset: a clearing pass over all 2048 nodes runs after reset and after every combine_op
//   write; no request beat is accepted until it ends
// ============================================================================
// lazy_range_tree_engine: lazy segment tree with range query, combine-update
// and assign over 1024 values; intake, command queue and tree sequencer
// ============================================================================
module lazy_range_tree_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                kind,
    input  logic [lrt_pkg::IDX_W-1:0] range_low,
    input  logic [lrt_pkg::IDX_W-1:0] range_high,
    input  lrt_pkg::val_t             value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output lrt_pkg::val_t             result_value,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                combine_op
);

    // intake to queue
    logic           push_valid;
    logic           push_ready;
    lrt_pkg::cmd_t  push_data;
    // queue to sequencer
    logic           pop_valid;
    logic           pop_ready;
    lrt_pkg::cmd_t  pop_data;
    // sequencer status back to intake
    lrt_pkg::stat_t stat;

    // clamps the range, turns empty updates and unused kinds into nothing
    lrt_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .range_low  (range_low),
        .range_high (range_high),
        .value      (value),
        .stat       (stat),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // two-entry queue lets intake keep taking beats while the tree is busy
    lrt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // walks both boundary paths: push-down, boundary nodes, ancestor rebuild
    lrt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .combine_op   (combine_op),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value)
    );

endmodule

// ===== tb/tb.sv =====
// ============================================================================
// tb: testbench of the lazy range tree engine
// drives range queries, combine-updates and assigns under all four combine
// functions, predicts every query result with a flat array model and checks
// each result beat in order
// ============================================================================
module tb;

    // flat model of the element array: a lazy tree and a flat array give the
    // same answers, so the predictor just walks the range
    class range_scoreboard;
        lrt_pkg::val_t  elems [lrt_pkg::SIZE];
        lrt_pkg::op_t   fn;
        lrt_pkg::val_t  pending_results [$];
        int             n_fail;
        int             n_checked;

        function void clear_all(lrt_pkg::op_t f);
            fn = f;
            foreach (elems[i])
                elems[i] = '0;
        endfunction

        function lrt_pkg::val_t fold(lrt_pkg::val_t x, lrt_pkg::val_t y);
            case (fn)
                lrt_pkg::OP_SUM:  return x + y;
                lrt_pkg::OP_MIN:  return (x < y) ? x : y;
                lrt_pkg::OP_MAX:  return (x > y) ? x : y;
                default:          return x ^ y;
            endcase
        endfunction

        function void note_request(logic [1:0] k, int lo, int hi, lrt_pkg::val_t v);
            lrt_pkg::val_t acc;
            if (hi > lrt_pkg::SIZE - 1)
                hi = lrt_pkg::SIZE - 1;
            acc = (fn == lrt_pkg::OP_MIN) ? '1 : '0;
            for (int i = lo; i <= hi; i++)
            begin
                if (k == lrt_pkg::KIND_QUERY)
                    acc = fold(acc, elems[i]);
                else if (k == lrt_pkg::KIND_COMB)
                    elems[i] = fold(elems[i], v);
                else if (k == lrt_pkg::KIND_ASSIGN)
                    elems[i] = v;
            end
            if (k == lrt_pkg::KIND_QUERY)
                pending_results.push_back(acc);
        endfunction

        function void check_result(lrt_pkg::val_t got);
            lrt_pkg::val_t want;
            n_checked++;
            if (pending_results.size() == 0)
            begin
                $error("result_value: none expected, actual %h", got);
                n_fail++;
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
            begin
                $error("result_value: expected %h, actual %h", want, got);
                n_fail++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [1:0]                kind;
    logic [lrt_pkg::IDX_W-1:0] range_low;
    logic [lrt_pkg::IDX_W-1:0] range_high;
    lrt_pkg::val_t             value;
    logic                      out_valid;
    logic                      out_ready;
    lrt_pkg::val_t             result_value;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [1:0]                combine_op;

    range_scoreboard sb;
    int  cycle_count;
    bit  hold_off_rx;   // receiver long stall request
    bit  rx_busy;       // receiver inside its long stall
    int  n_sent;

    localparam int CYCLE_LIMIT = 1500000;

    lazy_range_tree_engine u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .range_low    (range_low),
        .range_high   (range_high),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .combine_op   (combine_op)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // receiver: random stall per beat, plus one long hold-off on request
    initial
    begin
        int wait_n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_rx)
            begin
                rx_busy = 1'b1;
                out_ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_off_rx = 1'b0;
                rx_busy = 1'b0;
            end
            // at least half the time no stall at all, so stretches run full speed
            wait_n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 18);
            if (wait_n > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
            sb.check_result(result_value);
        end
    end

    // one request beat, with a random gap ahead of it when gaps is set; valid stays high
    // only when the next beat follows at once
    task automatic send_request(logic [1:0] k, int lo, int hi, lrt_pkg::val_t v, bit gaps);
        int gap_n;
        gap_n = gaps ? (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 18)) : 0;
        if (gap_n > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_n) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        range_low  <= lo[lrt_pkg::IDX_W-1:0];
        range_high <= hi[lrt_pkg::IDX_W-1:0];
        value      <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(k, lo, hi, v);
        n_sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0 || rx_busy)
            @(posedge clk);
        // updates give no result, so allow queued ones and the walk in progress to finish
        repeat (1000) @(posedge clk);
    endtask

    // combine_op write while idle; clears the store and the model
    task automatic set_function(lrt_pkg::op_t f);
        drain();
        cfg_valid  <= 1'b1;
        combine_op <= f;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.clear_all(f);
    endtask

    function automatic lrt_pkg::val_t rand_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // random request, mostly well-formed ranges with a mix of widths
    task automatic random_request;
        int lo;
        int hi;
        logic [1:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: k = lrt_pkg::KIND_QUERY;
            4, 5, 6:    k = lrt_pkg::KIND_COMB;
            7, 8:       k = lrt_pkg::KIND_ASSIGN;
            default:    k = lrt_pkg::KIND_UNUSED;
        endcase
        lo = $urandom_range(0, 1023);
        case ($urandom_range(0, 4))
            0:       hi = lo;
            1:       hi = lo + $urandom_range(0, 7);
            2:       hi = lo + $urandom_range(0, 100);
            3:       hi = $urandom_range(0, 1023);
            default: hi = $urandom_range(lo, 1023);
        endcase
        if (hi > 1023)
            hi = 1023;
        send_request(k, lo, hi, rand_value(), 1'b1);
    endtask

    task automatic directed_part;
        send_request(lrt_pkg::KIND_QUERY, 0, 1023, 32'h1234_5678, 1'b0);
        send_request(lrt_pkg::KIND_ASSIGN, 0, 1023, 32'hffff_ffff, 1'b1);
        send_request(lrt_pkg::KIND_COMB, 5, 900, 32'h8000_0001, 1'b0);
        send_request(lrt_pkg::KIND_QUERY, 0, 1023, 32'h0, 1'b1);
        send_request(lrt_pkg::KIND_QUERY, 7, 7, 32'h0, 1'b0);
        send_request(lrt_pkg::KIND_QUERY, 1023, 1023, 32'h0, 1'b0);
        // empty range for both query and update
        send_request(lrt_pkg::KIND_QUERY, 600, 599, 32'h0, 1'b1);
        send_request(lrt_pkg::KIND_COMB, 1023, 0, 32'hdead_beef, 1'b0);
        send_request(lrt_pkg::KIND_ASSIGN, 40, 39, 32'h5555_5555, 1'b0);
        // unused kind
        send_request(lrt_pkg::KIND_UNUSED, 0, 1023, 32'haaaa_aaaa, 1'b0);
        send_request(lrt_pkg::KIND_ASSIGN, 100, 200, 32'h0000_0003, 1'b1);
        send_request(lrt_pkg::KIND_COMB, 150, 250, 32'h0000_0005, 1'b0);
        send_request(lrt_pkg::KIND_QUERY, 90, 260, 32'hffff_ffff, 1'b0);
        send_request(lrt_pkg::KIND_ASSIGN, 512, 512, 32'h0, 1'b0);
        send_request(lrt_pkg::KIND_QUERY, 500, 520, 32'h0, 1'b0);
        send_request(lrt_pkg::KIND_QUERY, 0, 0, 32'h0, 1'b0);
    endtask

    initial
    begin
        lrt_pkg::op_t fn_plan [6];
        int           per_phase;
        sb = new();
        sb.clear_all(lrt_pkg::OP_SUM);
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = '0;
        range_low = '0;
        range_high = '0;
        value = '0;
        cfg_valid = 1'b0;
        combine_op = lrt_pkg::OP_SUM;
        hold_off_rx = 1'b0;
        rx_busy = 1'b0;
        cycle_count = 0;
        n_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        fn_plan = '{lrt_pkg::OP_SUM, lrt_pkg::OP_MIN, lrt_pkg::OP_MAX,
                    lrt_pkg::OP_XOR, lrt_pkg::OP_MIN, lrt_pkg::OP_SUM};
        // directed beats included, about 800 in all
        per_phase = (800 - 6 * 16) / 6;
        foreach (fn_plan[p])
        begin
            set_function(fn_plan[p]);
            directed_part();
            for (int n = 0; n < per_phase; n++)
            begin
                // long receiver hold-off while requests keep coming
                if (p == 1 && n == 20)
                    hold_off_rx = 1'b1;
                // sender pause until the block has answered everything
                if (n == per_phase / 2)
                    drain();
                random_request();
            end
        end
        drain();

        $display("tb: %0d request beats, %0d results checked, all four combine functions",
                 n_sent, sb.n_checked);
        $display("tb: assign, combine-update, query, empty, clamped and unused-kind cases");
        if (sb.n_fail == 0 && sb.pending_results.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
